// File: hw/rtl/scfr_pkg.sv
// Shared types and constants for the sync checksum frame receiver.
// Used by every module of the block; depends on nothing.
`default_nettype none

package scfr_pkg;

    localparam int FRAME_SIZE = 7;
    localparam logic [7:0] SYNC_MARK = 8'hFF;

    typedef struct packed {
        logic       sync;
        logic [7:0] data;
    } t_beat;

    typedef struct packed {
        logic [7:0] dev_address;
        logic [7:0] instr_high;
        logic [7:0] instr_low;
        logic [7:0] data_high;
        logic [7:0] data_low;
        logic [7:0] checksum_byte;
    } t_frame;

    typedef struct packed {
        logic  wr;
        t_beat beat;
    } t_q_wr;

endpackage

`default_nettype wire

// File: hw/rtl/sync_checksum_frame_receiver.sv
// Sync byte framed receiver with additive checksum, top level.
// Instantiates scfr_front, scfr_queue and scfr_back; depends on scfr_pkg.
//
// Input channel: drive i_rx_byte and raise i_push; a beat is taken at a
// clock edge with i_push high and o_full low. Up to one byte per cycle.
// Bytes are framed as sync 0xFF, address, two instruction bytes, two data
// bytes and a checksum over bytes 1 to 5 (sum modulo 256).
// Result channel: a good frame appears on the o_* fields while o_empty is
// low and is taken at an edge with i_pop high. Bad frames are dropped and
// the assembler resyncs on the first 0xFF among the buffered bytes.
// The frame's last byte is written into the queue, then read by the
// assembler, which registers the result, when no older byte waits in the
// queue. Throughput: one byte per cycle while no result waits, set by the
// single frame assembler, which retires one queued byte a cycle.
// Stall: while a result waits and i_pop is low, the assembler holds and up
// to QUEUE_DEPTH bytes gather in the queue before o_full rises.
// Reset (i_rst_n low, synchronous): the queue and the partial frame are
// emptied and any waiting result is discarded.
`default_nettype none

module sync_checksum_frame_receiver #(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_push,
    input  wire logic [7:0] i_rx_byte,
    output logic            o_full,
    output logic            o_empty,
    input  wire logic       i_pop,
    output logic [7:0]      o_dev_address,
    output logic [7:0]      o_instr_high,
    output logic [7:0]      o_instr_low,
    output logic [7:0]      o_data_high,
    output logic [7:0]      o_data_low,
    output logic [7:0]      o_checksum_byte
);
    import scfr_pkg::*;

    t_q_wr  q_wr;
    t_beat  rd_beat;
    t_frame res;
    logic   q_full;
    logic   rd_valid;
    logic   beat_take;
    logic   res_valid;

    scfr_front u_front (
        .i_push    (i_push),
        .i_rx_byte (i_rx_byte),
        .i_q_full  (q_full),
        .o_full    (o_full),
        .o_q_wr    (q_wr)
    );

    scfr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_wr     (q_wr),
        .o_full     (q_full),
        .o_rd_valid (rd_valid),
        .o_rd_beat  (rd_beat),
        .i_rd       (beat_take)
    );

    scfr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_beat_valid (rd_valid),
        .i_beat       (rd_beat),
        .o_beat_take  (beat_take),
        .i_pop        (i_pop),
        .o_res_valid  (res_valid),
        .o_res        (res)
    );

    assign o_empty         = !res_valid;
    assign o_dev_address   = res.dev_address;
    assign o_instr_high    = res.instr_high;
    assign o_instr_low     = res.instr_low;
    assign o_data_high     = res.data_high;
    assign o_data_low      = res.data_low;
    assign o_checksum_byte = res.checksum_byte;

endmodule

`default_nettype wire

// File: hw/rtl/scfr_front.sv
// Front end: accepts received bytes and tags sync bytes before queueing.
// Depends on scfr_pkg.
`default_nettype none

module scfr_front (
    input  wire logic          i_push,
    input  wire logic [7:0]    i_rx_byte,
    input  wire logic          i_q_full,
    output logic               o_full,
    output scfr_pkg::t_q_wr    o_q_wr
);
    import scfr_pkg::*;

    always_comb begin
        o_full           = i_q_full;
        o_q_wr.wr        = i_push && !i_q_full;
        o_q_wr.beat.sync = (i_rx_byte == SYNC_MARK);
        o_q_wr.beat.data = i_rx_byte;
    end

endmodule

`default_nettype wire

// File: hw/rtl/scfr_queue.sv
// Short beat queue between the front end and the frame assembler.
// Depends on scfr_pkg.
`default_nettype none

module scfr_queue #(
    parameter int DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire scfr_pkg::t_q_wr i_q_wr,
    output logic               o_full,
    output logic               o_rd_valid,
    output scfr_pkg::t_beat    o_rd_beat,
    input  wire logic          i_rd
);
    import scfr_pkg::*;

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW-1:0] LAST_IDX = AW'(DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

    t_beat          r_mem [DEPTH];
    logic [AW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;
    logic           rd_en;

    always_comb begin
        o_full     = (r_count == FULL_CNT);
        o_rd_valid = (r_count != '0);
        o_rd_beat  = r_mem[r_rd_ptr];
        rd_en      = i_rd && o_rd_valid;
        n_wr_ptr   = r_wr_ptr;
        n_rd_ptr   = r_rd_ptr;
        n_count    = r_count;
        if (i_q_wr.wr) begin
            n_wr_ptr = (r_wr_ptr == LAST_IDX) ? '0 : AW'(r_wr_ptr + 1'b1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == LAST_IDX) ? '0 : AW'(r_rd_ptr + 1'b1);
        end
        if (i_q_wr.wr && !rd_en) begin
            n_count = CW'(r_count + 1'b1);
        end else if (!i_q_wr.wr && rd_en) begin
            n_count = CW'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_q_wr.wr) begin
            r_mem[r_wr_ptr] <= i_q_wr.beat;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/scfr_back.sv
// Back end: assembles frames, checks the checksum, resyncs on bad frames
// and holds the result register. Depends on scfr_pkg.
`default_nettype none

module scfr_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_beat_valid,
    input  wire scfr_pkg::t_beat i_beat,
    output logic                 o_beat_take,
    input  wire logic            i_pop,
    output logic                 o_res_valid,
    output scfr_pkg::t_frame     o_res
);
    import scfr_pkg::*;

    localparam logic [2:0] LAST_POS = 3'(FRAME_SIZE - 1);
    localparam logic [2:0] FRAME_CNT = 3'(FRAME_SIZE);

    logic [7:0] r_buf [FRAME_SIZE];
    logic [7:0] n_buf [FRAME_SIZE];
    logic [2:0] r_held, n_held;
    logic       r_res_valid, n_res_valid;
    t_frame     r_res, n_res;

    logic [7:0] frame [FRAME_SIZE];
    logic [7:0] shifted [FRAME_SIZE];
    logic [7:0] sum;
    logic [2:0] pos;
    logic       found;

    always_comb begin
        frame    = r_buf;
        frame[FRAME_SIZE-1] = i_beat.data;
        sum      = 8'(frame[1] + frame[2] + frame[3] + frame[4] + frame[5]);

        found = 1'b0;
        pos   = '0;
        for (int i = FRAME_SIZE - 1; i >= 1; i--) begin
            if (frame[i] == SYNC_MARK) begin
                found = 1'b1;
                pos   = 3'(i);
            end
        end

        shifted = frame;
        for (int p = 1; p < FRAME_SIZE; p++) begin
            if (pos == 3'(p)) begin
                for (int j = 0; j < FRAME_SIZE - p; j++) begin
                    shifted[j] = frame[j + p];
                end
            end
        end
    end

    always_comb begin
        o_beat_take = i_beat_valid && (!r_res_valid || i_pop);
        n_buf       = r_buf;
        n_held      = r_held;
        n_res       = r_res;
        n_res_valid = r_res_valid && !i_pop;
        if (o_beat_take) begin
            priority if (r_held == '0) begin
                if (i_beat.sync) begin
                    n_buf[0] = i_beat.data;
                    n_held   = 3'd1;
                end
            end else if (r_held != LAST_POS) begin
                n_buf[r_held] = i_beat.data;
                n_held        = 3'(r_held + 3'd1);
            end else if (sum == i_beat.data) begin
                n_res.dev_address   = frame[1];
                n_res.instr_high    = frame[2];
                n_res.instr_low     = frame[3];
                n_res.data_high     = frame[4];
                n_res.data_low      = frame[5];
                n_res.checksum_byte = frame[6];
                n_res_valid         = 1'b1;
                n_held              = '0;
            end else begin
                n_buf  = shifted;
                n_held = found ? 3'(FRAME_CNT - pos) : '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held      <= '0;
            r_res_valid <= 1'b0;
        end else begin
            r_held      <= n_held;
            r_res_valid <= n_res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_buf <= n_buf;
        r_res <= n_res;
    end

    assign o_res_valid = r_res_valid;
    assign o_res       = r_res;

endmodule

`default_nettype wire

// File: hw/rtl/scfr_checker.sv
// Port-level checks for sync_checksum_frame_receiver and the bind that
// attaches them. Depends only on the top level's ports.
`default_nettype none

module scfr_port_sva (
    input wire logic       i_clk,
    input wire logic       i_rst_n,
    input wire logic       i_push,
    input wire logic [7:0] i_rx_byte,
    input wire logic       o_full,
    input wire logic       o_empty,
    input wire logic       i_pop,
    input wire logic [7:0] o_dev_address,
    input wire logic [7:0] o_instr_high,
    input wire logic [7:0] o_instr_low,
    input wire logic [7:0] o_data_high,
    input wire logic [7:0] o_data_low,
    input wire logic [7:0] o_checksum_byte
);

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> o_empty && !o_full)
        else $error("reset did not clear result and queue");

    a_checksum_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty |-> (8'(o_dev_address + o_instr_high + o_instr_low
                         + o_data_high + o_data_low) == o_checksum_byte))
        else $error("result with bad checksum");

    a_full_needs_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_full && !i_push |=> !o_full)
        else $error("full rose without a beat");

    a_result_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_empty && !i_pop |=> !o_empty && $stable(o_dev_address)
            && $stable(o_instr_high) && $stable(o_instr_low)
            && $stable(o_data_high) && $stable(o_data_low)
            && $stable(o_checksum_byte))
        else $error("waiting result changed");

endmodule

bind sync_checksum_frame_receiver scfr_port_sva u_scfr_port_sva (.*);

`default_nettype wire
